### rtl/s2cd_pkg.sv
package s2cd_pkg;

  localparam int UNIT_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_S,
    ST_DIV_M,
    ST_DIV_H,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  localparam logic [UNIT_W-1:0] DIV_SIXTY = 16'd60;
  localparam logic [UNIT_W-1:0] DIV_DAY   = 16'd24;
  localparam logic [UNIT_W-1:0] LEN_YEAR  = 16'd365;
  localparam logic [UNIT_W-1:0] LEN_LEAP  = 16'd366;

  localparam logic [4:0] LAST_S = 5'd31;
  localparam logic [4:0] LAST_M = 5'd26;
  localparam logic [4:0] LAST_H = 5'd20;
  localparam int SHIFT_M = 5;
  localparam int SHIFT_H = 11;

  localparam logic [11:0] YEAR_1970 = 12'd1970;
  localparam logic [11:0] YEAR_2000 = 12'd2000;
  localparam logic [1:0]  MOD4_1970   = 2'd2;
  localparam logic [6:0]  MOD100_1970 = 7'd70;
  localparam logic [8:0]  MOD400_1970 = 9'd370;
  localparam logic [6:0]  MOD100_LAST = 7'd99;
  localparam logic [8:0]  MOD400_LAST = 9'd399;
  localparam logic [2:0]  WD_1970 = 3'd4;
  localparam logic [2:0]  WD_2000 = 3'd6;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m)
      MONTH_FEB:                 d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

### rtl/s2cd_sub.sv
module s2cd_sub (
  input  logic [s2cd_pkg::UNIT_W-1:0] a,
  input  logic [s2cd_pkg::UNIT_W-1:0] b,
  output logic                        ge,
  output logic [s2cd_pkg::UNIT_W-1:0] diff
);
  import s2cd_pkg::*;

  assign ge   = (a >= b);
  assign diff = a - b;

endmodule

### rtl/seconds_to_calendar_date_top.sv
// Restoring division extracts seconds, minutes and hours in turn; then one year step
// per elapsed year plus a final one, up to 12 month steps, and an output step, all
// on the single shared compare-subtract unit.
// One item at a time: the next item is taken in the idle state after the result is in
// the output register, which is loaded only once out_valid is low or out_ready is high.
// Reset (rst, synchronous) clears the epoch to 1970 and empties the block.
module seconds_to_calendar_date_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        epoch_we,
  input  logic        epoch_select,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);
  import s2cd_pkg::*;

  state_t state, state_next;
  logic epoch;

  logic [31:0] num;
  logic [31:0] num_next;
  logic [5:0]  rem;
  logic [5:0]  rem_next;
  logic [4:0]  cnt;
  logic [5:0]  sec_w;
  logic [5:0]  min_w;
  logic [4:0]  hr_w;
  logic [2:0]  r7;
  logic [2:0]  r7_next;
  logic [3:0]  r7_sum;
  logic [15:0] doy;
  logic [11:0] yr;
  logic [1:0]  m4;
  logic [6:0]  m100;
  logic [8:0]  m400;
  logic [3:0]  mon;
  logic        leap;
  logic [3:0]  wd_sum;
  logic        load_out;

  logic [UNIT_W-1:0] op_a;
  logic [UNIT_W-1:0] op_b;
  logic              ge;
  logic [UNIT_W-1:0] diff;

  s2cd_sub u_sub (
    .a    (op_a),
    .b    (op_b),
    .ge   (ge),
    .diff (diff)
  );

  assign leap = (m4 == 2'd0) && ((m100 != 7'd0) || (m400 == 9'd0));

  assign num_next = {num[30:0], ge};
  assign rem_next = ge ? diff[5:0] : op_a[5:0];
  assign r7_sum   = {r7, ge};
  assign r7_next  = (r7_sum >= 4'd7) ? 3'(r7_sum - 4'd7) : r7_sum[2:0];
  assign wd_sum   = {1'b0, r7} + {1'b0, (epoch ? WD_2000 : WD_1970)};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIV_S;
      ST_DIV_S: if (cnt == 5'd0) state_next = ST_DIV_M;
      ST_DIV_M: if (cnt == 5'd0) state_next = ST_DIV_H;
      ST_DIV_H: if (cnt == 5'd0) state_next = ST_YEAR;
      ST_YEAR:  if (!ge) state_next = ST_MONTH;
      ST_MONTH: if (!ge || mon == MONTH_DEC) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    op_a     = {{(UNIT_W-7){1'b0}}, rem, num[31]};
    op_b     = DIV_SIXTY;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_DIV_S: op_b = DIV_SIXTY;
      ST_DIV_M: op_b = DIV_SIXTY;
      ST_DIV_H: op_b = DIV_DAY;
      ST_YEAR: begin
        op_a = doy;
        op_b = leap ? LEN_LEAP : LEN_YEAR;
      end
      ST_MONTH: begin
        op_a = doy;
        op_b = {11'd0, month_days(mon, leap)};
      end
      ST_DONE:  load_out = !out_valid || out_ready;
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      epoch <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (epoch_we) epoch <= epoch_select;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        num <= seconds;
        rem <= 6'd0;
        cnt <= LAST_S;
        r7  <= 3'd0;
        yr   <= epoch ? YEAR_2000 : YEAR_1970;
        m4   <= epoch ? 2'd0 : MOD4_1970;
        m100 <= epoch ? 7'd0 : MOD100_1970;
        m400 <= epoch ? 9'd0 : MOD400_1970;
      end
      ST_DIV_S, ST_DIV_M: begin
        cnt <= cnt - 5'd1;
        num <= num_next;
        rem <= rem_next;
        if (cnt == 5'd0) begin
          rem <= 6'd0;
          if (state == ST_DIV_S) begin
            sec_w <= rem_next;
            num   <= num_next << SHIFT_M;
            cnt   <= LAST_M;
          end else begin
            min_w <= rem_next;
            num   <= num_next << SHIFT_H;
            cnt   <= LAST_H;
          end
        end
      end
      ST_DIV_H: begin
        cnt <= cnt - 5'd1;
        num <= num_next;
        rem <= rem_next;
        r7  <= r7_next;
        if (cnt == 5'd0) begin
          hr_w <= rem_next[4:0];
          doy  <= num_next[15:0];
        end
      end
      ST_YEAR: begin
        if (ge) begin
          doy  <= diff;
          yr   <= yr + 12'd1;
          m4   <= m4 + 2'd1;
          m100 <= (m100 == MOD100_LAST) ? 7'd0 : m100 + 7'd1;
          m400 <= (m400 == MOD400_LAST) ? 9'd0 : m400 + 9'd1;
        end else begin
          mon <= MONTH_JAN;
        end
      end
      ST_MONTH: begin
        if (ge && mon != MONTH_DEC) begin
          doy <= diff;
          mon <= mon + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      second  <= sec_w;
      minute  <= min_w;
      hour    <= hr_w;
      weekday <= (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
      year    <= yr;
      month   <= mon;
      day     <= 5'(doy[4:0] + 5'd1);
    end
  end

  a_mod4: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR || state == ST_MONTH) |-> (m4 == yr[1:0]))
    else $error("year mod 4 counter out of step");

  a_mods: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR) |-> (m100 <= MOD100_LAST && m400 <= MOD400_LAST))
    else $error("century counters out of range");

  a_month: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONTH) |-> (mon >= MONTH_JAN && mon <= MONTH_DEC && doy < LEN_LEAP))
    else $error("month step out of range");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_DIV_S && cnt == LAST_S))
    else $error("accepted item did not start division");

  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (month >= MONTH_JAN && month <= MONTH_DEC && day != 5'd0
                          && second < 6'd60 && minute < 6'd60 && hour < 5'd24))
    else $error("result out of range");

endmodule
